>>> rtl/core/sps_pkg.sv
// shared types and constants for the packed 2bpp nearest scaler
// no dependencies
package sps_pkg;

  localparam int unsigned ImageBytes = 49152;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned SampW      = 18;
  localparam int unsigned DivSteps   = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  typedef enum logic [0:0] {
    KIND_WRITE   = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_IMAGE = 2'd1,
    ST_OUTSIDE   = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_ROW_BYTES  = 3'd2,
    REG_DST_WIDTH  = 3'd3,
    REG_DST_HEIGHT = 3'd4,
    REG_ORIGIN_X   = 3'd5,
    REG_ORIGIN_Y   = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [8:0]  src_width;
    logic [9:0]  src_height;
    logic [6:0]  row_bytes;
    logic [10:0] dst_width;
    logic [10:0] dst_height;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
  } cfg_t;

  // queue entry between front and back
  typedef struct packed {
    kind_e             kind;
    logic [AddrW-1:0]  byte_address;
    logic [7:0]        byte_value;
    logic [9:0]        out_col;
    logic [9:0]        out_row;
    status_e           status;
    logic [18:0]       num_x;
    logic [19:0]       num_y;
  } entry_t;

  // divider stage contents
  typedef struct packed {
    kind_e               kind;
    logic [AddrW-1:0]    byte_address;
    logic [7:0]          byte_value;
    logic [9:0]          out_col;
    logic [9:0]          out_row;
    status_e             status;
    logic [18:0]         rem_x;
    logic [19:0]         rem_y;
    logic [DivSteps-1:0] qx;
    logic [DivSteps-1:0] qy;
  } div_t;

endpackage

>>> rtl/core/sps_front.sv
// front part: accepts beats, classifies them and forms the scaling products
// depends on sps_pkg
module sps_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sps_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            kind_i,
  input  logic [15:0]     byte_address_i,
  input  logic [7:0]      byte_value_i,
  input  logic [9:0]      out_col_i,
  input  logic [9:0]      out_row_i,
  output logic            push_o,
  output sps_pkg::entry_t entry_o,
  input  logic            full_i
);

  logic            valid_q, valid_d;
  sps_pkg::entry_t entry_q, entry_d;
  logic [16:0]     total;
  logic            bad_image;
  logic            outside;
  logic            load;

  assign in_stall_o = valid_q && full_i;
  assign load       = !in_stall_o;
  assign push_o     = valid_q && !full_i;
  assign entry_o    = entry_q;

  always_comb begin
    total     = 17'(cfg_i.row_bytes) * 17'(cfg_i.src_height);
    bad_image = (cfg_i.row_bytes == '0) || (total == '0) ||
                (total > 17'(sps_pkg::ImageBytes));
    outside   = ({1'b0, out_col_i} >= cfg_i.dst_width) ||
                ({1'b0, out_row_i} >= cfg_i.dst_height);
    entry_d.kind         = sps_pkg::kind_e'(kind_i);
    entry_d.byte_address = byte_address_i;
    entry_d.byte_value   = byte_value_i;
    entry_d.out_col      = out_col_i;
    entry_d.out_row      = out_row_i;
    priority if (bad_image) begin
      entry_d.status = sps_pkg::ST_BAD_IMAGE;
    end else if (outside) begin
      entry_d.status = sps_pkg::ST_OUTSIDE;
    end else begin
      entry_d.status = sps_pkg::ST_OK;
    end
    entry_d.num_x = 19'(out_col_i) * 19'(cfg_i.src_width);
    entry_d.num_y = 20'(out_row_i) * 20'(cfg_i.src_height);
    valid_d = load ? in_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

>>> rtl/core/sps_queue.sv
// short queue between front and back
// depends on sps_pkg
module sps_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sps_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sps_pkg::entry_t entry_o
);

  sps_pkg::entry_t                  mem_q [sps_pkg::QueueDepth];
  logic [sps_pkg::QPtrW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [sps_pkg::QPtrW:0]          cnt_q, cnt_d;
  logic                             do_pop;

  assign full_o  = (cnt_q == (sps_pkg::QPtrW+1)'(sps_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (sps_pkg::QPtrW+1)'(push_i) - (sps_pkg::QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/sps_back.sv
// back part: pipelined dividers, image store and result register
// depends on sps_pkg
module sps_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sps_pkg::cfg_t   cfg_i,
  input  logic            empty_i,
  input  sps_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [10:0]     screen_col_o,
  output logic [10:0]     screen_row_o,
  output logic            ink_o,
  output logic [1:0]      status_o
);

  localparam int unsigned N = sps_pkg::DivSteps;

  logic          adv;
  logic          dv_q [N+1];
  sps_pkg::div_t dp_q [N+1];

  // address stage
  logic                      av_q;
  sps_pkg::kind_e            a_kind_q;
  logic [sps_pkg::SampW-1:0] a_addr_q;
  logic [7:0]                a_value_q;
  logic [9:0]                a_col_q, a_row_q;
  sps_pkg::status_e          a_status_q;
  logic [1:0]                a_sub_q;
  logic [sps_pkg::SampW-1:0] a_addr_d;

  // store stage
  logic             mv_q;
  logic             m_req_q;
  logic [9:0]       m_col_q, m_row_q;
  sps_pkg::status_e m_status_q;
  logic [1:0]       m_sub_q;
  logic             m_oor_q;
  logic [7:0]       m_data_q;
  logic [7:0]       store_q [sps_pkg::ImageBytes];
  logic             in_range;

  // result register
  logic        ov_q;
  logic [10:0] o_col_q, o_row_q;
  logic        o_ink_q;
  logic [1:0]  o_status_q;
  logic [1:0]  pix;
  logic [7:0]  byte_seen;

  assign adv   = !ov_q || !out_stall_i;
  assign pop_o = adv;

  always_comb begin
    dp_q[0].kind         = entry_i.kind;
    dp_q[0].byte_address = entry_i.byte_address;
    dp_q[0].byte_value   = entry_i.byte_value;
    dp_q[0].out_col      = entry_i.out_col;
    dp_q[0].out_row      = entry_i.out_row;
    dp_q[0].status       = entry_i.status;
    dp_q[0].rem_x        = entry_i.num_x;
    dp_q[0].rem_y        = entry_i.num_y;
    dp_q[0].qx           = '0;
    dp_q[0].qy           = '0;
    dv_q[0]              = !empty_i;
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_div
    localparam int unsigned B = N - 1 - k;
    sps_pkg::div_t nxt;
    logic [20:0]   dx, dy;
    always_comb begin
      nxt = dp_q[k];
      dx  = 21'(cfg_i.dst_width) << B;
      dy  = 21'(cfg_i.dst_height) << B;
      if (21'(dp_q[k].rem_x) >= dx) begin
        nxt.rem_x = 19'(21'(dp_q[k].rem_x) - dx);
        nxt.qx[B] = 1'b1;
      end
      if (21'(dp_q[k].rem_y) >= dy) begin
        nxt.rem_y = 20'(21'(dp_q[k].rem_y) - dy);
        nxt.qy[B] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_q[k+1] <= dv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dp_q[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    if (dp_q[N].kind == sps_pkg::KIND_WRITE) begin
      a_addr_d = sps_pkg::SampW'(dp_q[N].byte_address);
    end else begin
      a_addr_d = sps_pkg::SampW'(dp_q[N].qy * 17'(cfg_i.row_bytes)) +
                 sps_pkg::SampW'(dp_q[N].qx[N-1:2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0;
      mv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      av_q <= dv_q[N];
      mv_q <= av_q;
      ov_q <= mv_q && m_req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_kind_q   <= dp_q[N].kind;
      a_addr_q   <= a_addr_d;
      a_value_q  <= dp_q[N].byte_value;
      a_col_q    <= dp_q[N].out_col;
      a_row_q    <= dp_q[N].out_row;
      a_status_q <= dp_q[N].status;
      a_sub_q    <= dp_q[N].qx[1:0];
    end
  end

  assign in_range = (a_addr_q < sps_pkg::SampW'(sps_pkg::ImageBytes));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_req_q    <= (a_kind_q == sps_pkg::KIND_REQUEST);
      m_col_q    <= a_col_q;
      m_row_q    <= a_row_q;
      m_status_q <= a_status_q;
      m_sub_q    <= a_sub_q;
      m_oor_q    <= !in_range;
      m_data_q   <= store_q[a_addr_q[sps_pkg::AddrW-1:0]];
      if (av_q && a_kind_q == sps_pkg::KIND_WRITE && in_range) begin
        store_q[a_addr_q[sps_pkg::AddrW-1:0]] <= a_value_q;
      end
    end
  end

  // most significant pair is pixel 0
  always_comb begin
    byte_seen = m_oor_q ? 8'h00 : m_data_q;
    unique case (m_sub_q)
      2'd0:    pix = byte_seen[7:6];
      2'd1:    pix = byte_seen[5:4];
      2'd2:    pix = byte_seen[3:2];
      default: pix = byte_seen[1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_col_q    <= 11'(cfg_i.origin_x) + 11'(m_col_q);
      o_row_q    <= 11'(cfg_i.origin_y) + 11'(m_row_q);
      o_ink_q    <= (m_status_q == sps_pkg::ST_OK) && (pix != 2'd3);
      o_status_q <= m_status_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign screen_col_o = o_col_q;
  assign screen_row_o = o_row_q;
  assign ink_o        = o_ink_q;
  assign status_o     = o_status_q;

endmodule

>>> rtl/core/packed_2bpp_nearest_scaler.sv
// top level of the packed 2bpp nearest scaler: config registers, front, queue, back
// depends on sps_pkg, sps_front, sps_queue, sps_back
//
// channel   handshake               payload
// input     in_valid_i / in_stall_o kind, byte_address, byte_value, out_col, out_row
// output    out_valid_o/ out_stall_i screen_col, screen_row, ink, status
// config    cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one beat a cycle when not stalled; a request's result passes the front register,
// a queue slot, the ten-step divider pipeline, the address, store and result stages.
// reset clears the valid bits and loads the register defaults; the store is not cleared.
// an output stall freezes the back; the four-entry queue lets the front take beats until full.
module packed_2bpp_nearest_scaler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] byte_address_i,
  input  logic [7:0]  byte_value_i,
  input  logic [9:0]  out_col_i,
  input  logic [9:0]  out_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] screen_col_o,
  output logic [10:0] screen_row_o,
  output logic        ink_o,
  output logic [1:0]  status_o
);

  sps_pkg::cfg_t   cfg_q, cfg_d;
  logic            push, full, pop, empty;
  sps_pkg::entry_t f_entry, q_entry;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (sps_pkg::reg_idx_e'(cfg_idx_i))
        sps_pkg::REG_SRC_WIDTH:  cfg_d.src_width  = cfg_wdata_i[8:0];
        sps_pkg::REG_SRC_HEIGHT: cfg_d.src_height = cfg_wdata_i[9:0];
        sps_pkg::REG_ROW_BYTES:  cfg_d.row_bytes  = cfg_wdata_i[6:0];
        sps_pkg::REG_DST_WIDTH:  cfg_d.dst_width  = cfg_wdata_i;
        sps_pkg::REG_DST_HEIGHT: cfg_d.dst_height = cfg_wdata_i;
        sps_pkg::REG_ORIGIN_X:   cfg_d.origin_x   = cfg_wdata_i[9:0];
        sps_pkg::REG_ORIGIN_Y:   cfg_d.origin_y   = cfg_wdata_i[9:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= 9'd1;
      cfg_q.src_height <= 10'd1;
      cfg_q.row_bytes  <= 7'd1;
      cfg_q.dst_width  <= 11'd1;
      cfg_q.dst_height <= 11'd1;
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sps_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .byte_address_i (byte_address_i),
    .byte_value_i   (byte_value_i),
    .out_col_i      (out_col_i),
    .out_row_i      (out_row_i),
    .push_o         (push),
    .entry_o        (f_entry),
    .full_i         (full)
  );

  sps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (q_entry)
  );

  sps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (empty),
    .entry_i      (q_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .screen_col_o (screen_col_o),
    .screen_row_o (screen_row_o),
    .ink_o        (ink_o),
    .status_o     (status_o)
  );

endmodule
